/* rtl/cqs_pkg.sv */
// Package for the circular queue with search: beat types, operation and
// status codes, controller state type. No dependencies.
`default_nettype none

package cqs_pkg;

  // Operation codes of a request beat
  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_REMOVE = 2'd1;
  localparam logic [1:0] OP_SEARCH = 2'd2;

  // Status codes of a response beat
  localparam logic [2:0] ST_OK    = 3'd0;
  localparam logic [2:0] ST_FULL  = 3'd1;
  localparam logic [2:0] ST_EMPTY = 3'd2;
  localparam logic [2:0] ST_MATCH = 3'd3;
  localparam logic [2:0] ST_DONE  = 3'd4;

  typedef struct packed {
    logic [1:0]         operation;
    logic signed [31:0] value;
  } in_t;

  typedef struct packed {
    logic [2:0]         status;
    logic signed [31:0] data;
    logic [5:0]         position;
    logic               last;
  } out_t;

  // Result offered by the controller to the output register
  typedef struct packed {
    logic valid;
    out_t item;
  } res_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_REM,
    S_CMP,
    S_DONE
  } state_t;

endpackage

`default_nettype wire

/* rtl/cqs_ram.sv */
// Slot storage: one write port, one read port, registered read data.
// Depends on nothing; address width is set by AW, which the top level derives from DEPTH.
`default_nettype none

module cqs_ram #(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [AW-1:0]     waddr,
  input  wire logic signed [31:0] wdata,
  input  wire logic              re,
  input  wire logic [AW-1:0]     raddr,
  output logic signed [31:0]     rdata
);

  logic signed [31:0] mem [DEPTH];

  // Write slot
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read slot; data holds while no read is issued
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

/* rtl/cqs_ctrl.sv */
// Queue controller: head/tail pointers, request decode, search sequencer.
// Depends on cqs_pkg; drives the ports of cqs_ram.
`default_nettype none

module cqs_ctrl #(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               req_valid,
  input  wire cqs_pkg::in_t       req,
  output logic                    req_stall,
  input  wire logic               ospace,
  output cqs_pkg::res_t           res,
  output logic                    we,
  output logic [AW-1:0]           waddr,
  output logic signed [31:0]      wdata,
  output logic                    re,
  output logic [AW-1:0]           raddr,
  input  wire logic signed [31:0] rdata
);

  localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);

  cqs_pkg::state_t    state, state_next;
  logic [AW-1:0]      head, head_next;
  logic [AW-1:0]      tail, tail_next;
  logic [AW-1:0]      ptr, ptr_next;
  logic [AW-1:0]      pos, pos_next;
  logic [AW-1:0]      remain, remain_next;
  logic signed [31:0] key, key_next;

  logic          accept;
  logic          full;
  logic          empty;
  logic          match;
  logic          hold;
  logic [AW:0]   diff;
  logic [AW-1:0] occupancy;

  function automatic logic [AW-1:0] next_ptr(input logic [AW-1:0] p);
    return (p == LAST_IDX) ? '0 : p + 1'b1;
  endfunction

  // Decode queue status
  assign req_stall = !((state == cqs_pkg::S_IDLE) && ospace);
  assign accept    = req_valid && !req_stall;
  assign full      = (next_ptr(tail) == head);
  assign empty     = (head == tail);
  assign match     = (rdata == key);
  assign hold      = match && !ospace;

  // Count occupied slots, wrapping at DEPTH
  always_comb begin
    diff = {1'b0, tail} - {1'b0, head};
    if (tail < head) begin
      diff = diff + (AW+1)'(DEPTH);
    end
    occupancy = diff[AW-1:0];
  end

  // Next state and register updates
  always_comb begin
    state_next  = state;
    head_next   = head;
    tail_next   = tail;
    ptr_next    = ptr;
    pos_next    = pos;
    remain_next = remain;
    key_next    = key;
    unique case (state)
      cqs_pkg::S_IDLE: begin
        if (accept) begin
          unique case (req.operation)
            cqs_pkg::OP_INSERT: begin
              if (!full) begin
                tail_next = next_ptr(tail);
              end
            end
            cqs_pkg::OP_REMOVE: begin
              if (!empty) begin
                head_next  = next_ptr(head);
                state_next = cqs_pkg::S_REM;
              end
            end
            cqs_pkg::OP_SEARCH: begin
              key_next = req.value;
              if (empty) begin
                state_next = cqs_pkg::S_DONE;
              end else begin
                ptr_next    = next_ptr(head);
                pos_next    = AW'(1);
                remain_next = occupancy - 1'b1;
                state_next  = cqs_pkg::S_CMP;
              end
            end
            default: begin
            end
          endcase
        end
      end
      cqs_pkg::S_REM: begin
        if (ospace) begin
          state_next = cqs_pkg::S_IDLE;
        end
      end
      cqs_pkg::S_CMP: begin
        if (!hold) begin
          if (remain != '0) begin
            ptr_next    = next_ptr(ptr);
            pos_next    = pos + 1'b1;
            remain_next = remain - 1'b1;
          end else begin
            state_next = cqs_pkg::S_DONE;
          end
        end
      end
      cqs_pkg::S_DONE: begin
        if (ospace) begin
          state_next = cqs_pkg::S_IDLE;
        end
      end
      default: state_next = cqs_pkg::S_IDLE;
    endcase
  end

  // Outputs: result beat and slot accesses
  always_comb begin
    res.valid         = 1'b0;
    res.item.status   = cqs_pkg::ST_OK;
    res.item.data     = '0;
    res.item.position = '0;
    res.item.last     = 1'b1;
    we    = 1'b0;
    waddr = next_ptr(tail);
    wdata = req.value;
    re    = 1'b0;
    raddr = next_ptr(head);
    unique case (state)
      cqs_pkg::S_IDLE: begin
        if (accept) begin
          unique case (req.operation)
            cqs_pkg::OP_INSERT: begin
              res.valid       = 1'b1;
              res.item.status = full ? cqs_pkg::ST_FULL : cqs_pkg::ST_OK;
              we              = !full;
            end
            cqs_pkg::OP_REMOVE: begin
              if (empty) begin
                res.valid       = 1'b1;
                res.item.status = cqs_pkg::ST_EMPTY;
              end else begin
                re = 1'b1;
              end
            end
            cqs_pkg::OP_SEARCH: begin
              re = !empty;
            end
            default: begin
            end
          endcase
        end
      end
      cqs_pkg::S_REM: begin
        res.valid     = ospace;
        res.item.data = rdata;
      end
      cqs_pkg::S_CMP: begin
        raddr = next_ptr(ptr);
        if (!hold) begin
          res.valid         = match;
          res.item.status   = cqs_pkg::ST_MATCH;
          res.item.position = 6'(pos);
          res.item.last     = 1'b0;
          re                = (remain != '0);
        end
      end
      cqs_pkg::S_DONE: begin
        res.valid       = ospace;
        res.item.status = cqs_pkg::ST_DONE;
      end
      default: begin
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= cqs_pkg::S_IDLE;
      head  <= LAST_IDX;
      tail  <= LAST_IDX;
    end else begin
      state <= state_next;
      head  <= head_next;
      tail  <= tail_next;
    end
  end

  // Search registers, loaded when a search starts and stepped as it runs
  always_ff @(posedge clk) begin
    ptr    <= ptr_next;
    pos    <= pos_next;
    remain <= remain_next;
    key    <= key_next;
  end

endmodule

`default_nettype wire

/* rtl/circular_queue_with_search.sv */
// Top level of the circular queue with search: controller, slot memory,
// output register. Depends on cqs_pkg, cqs_ram, cqs_ctrl.
//
//   channel  beat    fields                              handshake
//   req      in_t    operation, value                    req_valid / req_stall
//   rsp      out_t   status, data, position, last        rsp_valid / rsp_stall
//
// Insert offers its result when taken; remove of a non-empty queue first reads one slot.
// Search visits the N occupied slots in order: the single read port
// delivers one slot per cycle, and a match held by rsp_stall pauses it.
// Reset sets head and tail to DEPTH-1; slots are not cleared.
// A result waits in the output register while rsp_stall is high; the
// next request is taken once the controller is idle and that register can accept a beat.
`default_nettype none

module circular_queue_with_search #(
  parameter int DEPTH = 64
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          req_valid,
  output logic               req_stall,
  input  wire cqs_pkg::in_t  req,
  output logic               rsp_valid,
  input  wire logic          rsp_stall,
  output cqs_pkg::out_t      rsp
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  cqs_pkg::res_t      res;
  logic               ospace;
  logic               we;
  logic [AW-1:0]      waddr;
  logic signed [31:0] wdata;
  logic               re;
  logic [AW-1:0]      raddr;
  logic signed [31:0] rdata;

  cqs_ctrl #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req       (req),
    .req_stall (req_stall),
    .ospace    (ospace),
    .res       (res),
    .we        (we),
    .waddr     (waddr),
    .wdata     (wdata),
    .re        (re),
    .raddr     (raddr),
    .rdata     (rdata)
  );

  cqs_ram #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (re),
    .raddr (raddr),
    .rdata (rdata)
  );

  // Output register takes a beat when empty or being drained
  assign ospace = !rsp_valid || !rsp_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (ospace) begin
      rsp_valid <= res.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ospace && res.valid) begin
      rsp <= res.item;
    end
  end

  // Controller offers a result only when the output register has room
  a_res_room : assert property (@(posedge clk) disable iff (rst)
    res.valid |-> ospace)
    else $error("result offered while output register is full");

  // A search occupies the controller for the following cycle
  a_busy_after : assert property (@(posedge clk) disable iff (rst)
    (req_valid && !req_stall && req.operation == cqs_pkg::OP_SEARCH) |=> req_stall)
    else $error("request taken while search in progress");

  // Only match beats are not the final beat of a request
  a_last_match : assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && !rsp.last) |-> (rsp.status == cqs_pkg::ST_MATCH))
    else $error("non-final beat without match status");

endmodule

`default_nettype wire
